FILE: sv/xxh_pkg.sv
// Shared types, constants and helpers for the streaming XXH32 hasher.
`timescale 1ns / 1ps

package xxh_pkg;

    localparam logic [31:0] PRIME1 = 32'h9E3779B1;
    localparam logic [31:0] PRIME2 = 32'h85EBCA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
    localparam logic [31:0] PRIME5 = 32'h165667B1;

    // register index of hash_seed, taken from paddr[2]
    localparam logic REG_HASH_SEED = 1'b0;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE     = 5'd0;
    localparam t_op OP_DROP     = 5'd1;
    localparam t_op OP_TAKE     = 5'd2;
    localparam t_op OP_RND_MUL1 = 5'd3;
    localparam t_op OP_RND_ADD  = 5'd4;
    localparam t_op OP_RND_MUL2 = 5'd5;
    localparam t_op OP_FIN_INIT = 5'd6;
    localparam t_op OP_FIN_ADD2 = 5'd7;
    localparam t_op OP_FIN_ADD3 = 5'd8;
    localparam t_op OP_FIN_LEN  = 5'd9;
    localparam t_op OP_IDX_CLR  = 5'd10;
    localparam t_op OP_WRD_MUL1 = 5'd11;
    localparam t_op OP_WRD_ADD  = 5'd12;
    localparam t_op OP_WRD_MUL2 = 5'd13;
    localparam t_op OP_BYT_MUL1 = 5'd14;
    localparam t_op OP_BYT_ADD  = 5'd15;
    localparam t_op OP_BYT_MUL2 = 5'd16;
    localparam t_op OP_AV1      = 5'd17;
    localparam t_op OP_AV2      = 5'd18;
    localparam t_op OP_AV3      = 5'd19;

    typedef struct packed {
        logic in_full;     // incoming item carries four (or more) bytes
        logic wis_full;    // three words buffered: next full word closes the stripe
        logic last_item;   // captured item was the final one
        logic seen;        // at least one stripe folded into the lanes
        logic lane_last;   // lane index points at lane 3
        logic words_done;  // buffered words all folded
        logic bytes_done;  // tail bytes all folded
    } t_dp_status;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

FILE: sv/xxh_datapath.sv
// Datapath: lane accumulators, stripe buffer, length, shared multiplier and hash register.
`timescale 1ns / 1ps

module xxh_datapath import xxh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  logic [31:0] i_seed,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last,
    output t_dp_status  o_status,
    output logic [31:0] o_hash_value,
    output logic        o_format_error
);

    logic [31:0] r_word;
    logic [2:0]  r_cnt;
    logic        r_last;
    logic [31:0] r_words [3];
    logic [1:0]  r_wis;
    logic [31:0] r_len;
    logic        r_seen;
    logic        r_err;
    logic [31:0] r_lanes [4];
    logic [1:0]  r_idx;
    logic [31:0] r_prod;
    logic [31:0] r_acc;
    logic [31:0] r_hash;
    logic        r_ferr;

    logic [2:0]  in_cnt;
    logic [31:0] word_sel;
    logic [31:0] round_src;
    logic [7:0]  byte_sel;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_p;

    // counts above four are treated as four
    assign in_cnt = i_byte_count[2] ? 3'd4 : i_byte_count;

    always_comb begin
        case (r_idx)
            2'd0:    word_sel = r_words[0];
            2'd1:    word_sel = r_words[1];
            2'd2:    word_sel = r_words[2];
            default: word_sel = r_word;
        endcase
    end

    // lane 3 takes the word that closed the stripe
    assign round_src = word_sel;

    always_comb begin
        case (r_idx)
            2'd0:    byte_sel = r_word[7:0];
            2'd1:    byte_sel = r_word[15:8];
            2'd2:    byte_sel = r_word[23:16];
            default: byte_sel = r_word[31:24];
        endcase
    end

    always_comb begin
        case (i_op)
            OP_RND_MUL1: begin mul_a = round_src;               mul_b = PRIME2; end
            OP_RND_MUL2: begin mul_a = r_acc;                   mul_b = PRIME1; end
            OP_WRD_MUL1: begin mul_a = word_sel;                mul_b = PRIME3; end
            OP_WRD_MUL2: begin mul_a = r_acc;                   mul_b = PRIME4; end
            OP_BYT_MUL1: begin mul_a = {24'd0, byte_sel};       mul_b = PRIME5; end
            OP_BYT_MUL2: begin mul_a = r_acc;                   mul_b = PRIME1; end
            OP_AV1:      begin mul_a = r_acc ^ (r_acc >> 15);   mul_b = PRIME2; end
            OP_AV2:      begin mul_a = r_acc ^ (r_acc >> 13);   mul_b = PRIME3; end
            default:     begin mul_a = '0;                      mul_b = '0;     end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wis  <= '0;
            r_len  <= '0;
            r_seen <= 1'b0;
            r_err  <= 1'b0;
        end else begin
            case (i_op)
                OP_DROP: r_err <= 1'b1;
                OP_TAKE: begin
                    r_len <= r_len + {29'd0, in_cnt};
                    if (i_byte_count[2]) begin
                        if (r_wis != 2'd3) begin
                            r_wis <= r_wis + 2'd1;
                        end else begin
                            r_seen <= 1'b1;
                        end
                    end
                end
                OP_RND_MUL2: begin
                    if (r_idx == 2'd3) begin
                        r_wis <= '0;
                    end
                end
                OP_AV3: begin
                    r_wis  <= '0;
                    r_len  <= '0;
                    r_seen <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_TAKE: begin
                r_word <= i_data_word;
                r_cnt  <= in_cnt;
                r_last <= i_last;
                r_idx  <= '0;
                if (i_byte_count[2]) begin
                    if (r_wis != 2'd3) begin
                        r_words[r_wis] <= i_data_word;
                    end else if (!r_seen) begin
                        r_lanes[0] <= i_seed + PRIME1 + PRIME2;
                        r_lanes[1] <= i_seed + PRIME2;
                        r_lanes[2] <= i_seed;
                        r_lanes[3] <= i_seed - PRIME1;
                    end
                end
            end
            OP_RND_MUL1: r_prod <= mul_p;
            OP_RND_ADD:  r_acc  <= rotl32(r_lanes[r_idx] + r_prod, 13);
            OP_RND_MUL2: begin
                r_lanes[r_idx] <= mul_p;
                r_idx          <= r_idx + 2'd1;
            end
            OP_FIN_INIT: begin
                r_idx <= '0;
                if (r_seen) begin
                    r_acc <= rotl32(r_lanes[0], 1) + rotl32(r_lanes[1], 7);
                end else begin
                    r_acc <= i_seed + PRIME5;
                end
            end
            OP_FIN_ADD2: r_acc <= r_acc + rotl32(r_lanes[2], 12);
            OP_FIN_ADD3: r_acc <= r_acc + rotl32(r_lanes[3], 18);
            OP_FIN_LEN:  r_acc <= r_acc + r_len;
            OP_IDX_CLR:  r_idx <= '0;
            OP_WRD_MUL1: r_prod <= mul_p;
            OP_WRD_ADD:  r_acc  <= rotl32(r_acc + r_prod, 17);
            OP_WRD_MUL2: begin
                r_acc <= mul_p;
                r_idx <= r_idx + 2'd1;
            end
            OP_BYT_MUL1: r_prod <= mul_p;
            OP_BYT_ADD:  r_acc  <= rotl32(r_acc + r_prod, 11);
            OP_BYT_MUL2: begin
                r_acc <= mul_p;
                r_idx <= r_idx + 2'd1;
            end
            OP_AV1: r_acc <= mul_p;
            OP_AV2: r_acc <= mul_p;
            OP_AV3: begin
                r_hash <= r_acc ^ (r_acc >> 16);
                r_ferr <= r_err;
            end
            default: ;
        endcase
    end

    assign o_status.in_full    = i_byte_count[2];
    assign o_status.wis_full   = (r_wis == 2'd3);
    assign o_status.last_item  = r_last;
    assign o_status.seen       = r_seen;
    assign o_status.lane_last  = (r_idx == 2'd3);
    assign o_status.words_done = (r_idx == r_wis);
    assign o_status.bytes_done = r_cnt[2] || (r_idx == r_cnt[1:0]);

    assign o_hash_value   = r_hash;
    assign o_format_error = r_ferr;

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_err))
        else $error("sticky error flag cleared");

    a_stripe_clears_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_RND_MUL2 && r_idx == 2'd3) |=> (r_wis == 2'd0))
        else $error("stripe buffer not emptied after last lane round");

    a_message_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_AV3) |=> (r_len == 32'd0 && !r_seen && r_wis == 2'd0))
        else $error("message state not cleared after result");

endmodule

FILE: sv/xxh_ctrl.sv
// Controller: sequences item intake, lane rounds, finalization and the result register.
`timescale 1ns / 1ps

module xxh_ctrl import xxh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_last,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_op        o_op
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RND_A    = 5'd1;
    localparam logic [4:0] S_RND_B    = 5'd2;
    localparam logic [4:0] S_RND_C    = 5'd3;
    localparam logic [4:0] S_FIN_INIT = 5'd4;
    localparam logic [4:0] S_FIN_ADD2 = 5'd5;
    localparam logic [4:0] S_FIN_ADD3 = 5'd6;
    localparam logic [4:0] S_FIN_LEN  = 5'd7;
    localparam logic [4:0] S_WRD_A    = 5'd8;
    localparam logic [4:0] S_WRD_B    = 5'd9;
    localparam logic [4:0] S_WRD_C    = 5'd10;
    localparam logic [4:0] S_BYT_A    = 5'd11;
    localparam logic [4:0] S_BYT_B    = 5'd12;
    localparam logic [4:0] S_BYT_C    = 5'd13;
    localparam logic [4:0] S_AV1      = 5'd14;
    localparam logic [4:0] S_AV2      = 5'd15;
    localparam logic [4:0] S_AV3      = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_last && !i_status.in_full) begin
                        o_op = OP_DROP;
                    end else begin
                        o_op = OP_TAKE;
                        if (i_status.in_full && i_status.wis_full) begin
                            n_state = S_RND_A;
                        end else if (i_last) begin
                            n_state = S_FIN_INIT;
                        end
                    end
                end
            end
            S_RND_A: begin
                o_op    = OP_RND_MUL1;
                n_state = S_RND_B;
            end
            S_RND_B: begin
                o_op    = OP_RND_ADD;
                n_state = S_RND_C;
            end
            S_RND_C: begin
                o_op = OP_RND_MUL2;
                if (!i_status.lane_last) begin
                    n_state = S_RND_A;
                end else if (i_status.last_item) begin
                    n_state = S_FIN_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN_INIT: begin
                o_op    = OP_FIN_INIT;
                n_state = i_status.seen ? S_FIN_ADD2 : S_FIN_LEN;
            end
            S_FIN_ADD2: begin
                o_op    = OP_FIN_ADD2;
                n_state = S_FIN_ADD3;
            end
            S_FIN_ADD3: begin
                o_op    = OP_FIN_ADD3;
                n_state = S_FIN_LEN;
            end
            S_FIN_LEN: begin
                o_op    = OP_FIN_LEN;
                n_state = S_WRD_A;
            end
            S_WRD_A: begin
                if (i_status.words_done) begin
                    o_op    = OP_IDX_CLR;
                    n_state = S_BYT_A;
                end else begin
                    o_op    = OP_WRD_MUL1;
                    n_state = S_WRD_B;
                end
            end
            S_WRD_B: begin
                o_op    = OP_WRD_ADD;
                n_state = S_WRD_C;
            end
            S_WRD_C: begin
                o_op    = OP_WRD_MUL2;
                n_state = S_WRD_A;
            end
            S_BYT_A: begin
                if (i_status.bytes_done) begin
                    n_state = S_AV1;
                end else begin
                    o_op    = OP_BYT_MUL1;
                    n_state = S_BYT_B;
                end
            end
            S_BYT_B: begin
                o_op    = OP_BYT_ADD;
                n_state = S_BYT_C;
            end
            S_BYT_C: begin
                o_op    = OP_BYT_MUL2;
                n_state = S_BYT_A;
            end
            S_AV1: begin
                o_op    = OP_AV1;
                n_state = S_AV2;
            end
            S_AV2: begin
                o_op    = OP_AV2;
                n_state = S_AV3;
            end
            S_AV3: begin
                // wait here until the result register is free
                if (out_free) begin
                    o_op    = OP_AV3;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_AV3 && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AV3 && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished hash not posted to result register");

endmodule

FILE: sv/xxhash32_stream_hasher.sv
// Top level of the streaming XXH32 hasher: configuration register and module wiring.
//
// Input channel (i_in_valid / o_in_ready) carries one little-endian word per transfer:
// i_data_word, i_byte_count (0..4 valid low bytes, counts above 4 act as 4) and i_last.
// Every item but the last must carry four bytes; a short non-final item is dropped
// and sets a sticky error that is reported with every later hash until reset.
// Output channel (o_out_valid / i_out_ready) carries one transfer per message:
// o_hash_value and o_format_error.
// hash_seed sits at APB byte address 0; write it only while the block is idle.
// All arithmetic runs through the single shared 32x32 multiplier in controller order:
// a buffered word is only stored, while the word that closes a 16-byte stripe is then
// folded in by four lane rounds. After the last item come the merge (its lane steps
// only once a stripe was seen), a round per buffered word, a round per tail byte and
// the avalanche until the result is valid, preceded by lane rounds if it closes a stripe.
// The result register lets the next message stream in while a hash waits; only the
// next final item stalls, in its last step, until the receiver takes the pending hash.
// Reset clears the seed, the sticky error, the message state and the result valid.
`timescale 1ns / 1ps

module xxhash32_stream_hasher import xxh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_hash_value,
    output logic        o_format_error
);

    logic [31:0] r_seed;
    t_op         op;
    t_dp_status  status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HASH_SEED) ? r_seed : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_HASH_SEED) begin
            r_seed <= pwdata;
        end
    end

    xxh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_last),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_op        (op)
    );

    xxh_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_seed         (r_seed),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_last         (i_last),
        .o_status       (status),
        .o_hash_value   (o_hash_value),
        .o_format_error (o_format_error)
    );

endmodule
